// ===== rtl/grid_peak_counter_assert.svh =====
// assertion macros for the grid peak counter
// no dependencies; included by the top level
`ifndef GRID_PEAK_COUNTER_ASSERT_SVH
`define GRID_PEAK_COUNTER_ASSERT_SVH
`ifndef SYNTHESIS
`define GPC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grid_peak_counter check failed");
`define GPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grid_peak_counter check failed");
`else
`define GPC_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define GPC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/gpc_pkg.sv =====
// shared types, constants and helpers for the grid peak counter
// no dependencies
package gpc_pkg;
   localparam int MAX_ROWS_DEF = 16;
   localparam int MAX_COLS_DEF = 1024;
   localparam int HEIGHT_W = 31;
   localparam int COUNT_W = 15;
   localparam int OPCODE_W = 2;
   localparam int ROW_W = 4;
   localparam int COL_W = 10;
   localparam int ROWS_CFG_W = 5;
   localparam int COLS_CFG_W = 11;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 11;
   localparam int GR_W = 6;
   localparam int GC_W = 12;
   localparam int RC_W = 7;
   localparam int CC_W = 13;

   localparam logic [OPCODE_W-1:0] OP_LOAD = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_RECOUNT = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_UPDATE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b1;

   localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 5'd16;
   localparam logic [COLS_CFG_W-1:0] COLS_RESET = 11'd1024;

   typedef struct packed {
      logic start;
      logic signed [RC_W-1:0] row;
      logic signed [CC_W-1:0] col;
   } gpc_eval_req_type;

   typedef struct packed {
      logic done;
      logic peak;
   } gpc_eval_res_type;

   function automatic logic gpc_in_grid(logic signed [RC_W-1:0] r,
                                        logic signed [CC_W-1:0] c,
                                        logic [GR_W-1:0] gr,
                                        logic [GC_W-1:0] gc);
      logic r_ok;
      logic c_ok;
      r_ok = !r[RC_W-1] && (r < signed'({1'b0, gr}));
      c_ok = !c[CC_W-1] && (c < signed'({1'b0, gc}));
      return r_ok && c_ok;
   endfunction
endpackage

// ===== rtl/gpc_height_mem.sv =====
// height map storage: one write port, one registered read port
// no dependencies
module gpc_height_mem #(
   parameter int DEPTH = 16384,
   parameter int AW = 14,
   parameter int DW = 31
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);
   logic [DW-1:0] height_ff [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         height_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= height_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/gpc_peak_eval.sv =====
// peak test of one cell: reads the cell and its four neighbors in turn
// depends on gpc_pkg
module gpc_peak_eval #(
   parameter int MAX_COLS = 1024,
   parameter int AW = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gpc_pkg::gpc_eval_req_type     req,
   input  logic [gpc_pkg::GR_W-1:0]      grid_rows,
   input  logic [gpc_pkg::GC_W-1:0]      grid_cols,
   input  logic [gpc_pkg::HEIGHT_W-1:0]  rd_data,
   output logic                          rd_en,
   output logic [AW-1:0]                 rd_addr,
   output gpc_pkg::gpc_eval_res_type     res
);
   import gpc_pkg::*;

   logic busy_ff, busy_in;
   logic [2:0] step_ff, step_in;
   logic signed [RC_W-1:0] row_ff, row_in;
   logic signed [CC_W-1:0] col_ff, col_in;
   logic prev_in_ff, prev_in_in;
   logic center_in_ff, center_in_in;
   logic [HEIGHT_W-1:0] center_h_ff, center_h_in;
   logic ok_ff, ok_in;
   logic signed [RC_W-1:0] nb_row;
   logic signed [CC_W-1:0] nb_col;
   logic nb_in;
   logic higher;

   always_comb begin
      nb_row = row_ff;
      nb_col = col_ff;
      unique case (step_ff)
         3'd1: nb_row = row_ff - RC_W'(1);
         3'd2: nb_row = row_ff + RC_W'(1);
         3'd3: nb_col = col_ff - CC_W'(1);
         3'd4: nb_col = col_ff + CC_W'(1);
         default: ;
      endcase
   end

   assign nb_in = gpc_in_grid(nb_row, nb_col, grid_rows, grid_cols);
   assign rd_en = busy_ff && (step_ff <= 3'd4) && nb_in;
   assign rd_addr = AW'(32'(nb_row[RC_W-2:0]) * 32'(MAX_COLS) + 32'(nb_col[CC_W-2:0]));
   assign higher = prev_in_ff && (rd_data > center_h_ff);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      row_in = row_ff;
      col_in = col_ff;
      prev_in_in = prev_in_ff;
      center_in_in = center_in_ff;
      center_h_in = center_h_ff;
      ok_in = ok_ff;
      res.done = 1'b0;
      res.peak = 1'b0;
      if (!busy_ff) begin
         if (req.start) begin
            busy_in = 1'b1;
            step_in = 3'd0;
            row_in = req.row;
            col_in = req.col;
            ok_in = 1'b1;
         end
      end else begin
         prev_in_in = nb_in;
         if (step_ff == 3'd1) begin
            center_in_in = prev_in_ff;
            center_h_in = rd_data;
         end else if (step_ff != 3'd0 && higher) begin
            ok_in = 1'b0;
         end
         if (step_ff == 3'd5) begin
            busy_in = 1'b0;
            res.done = 1'b1;
            res.peak = center_in_ff && ok_ff && !higher;
         end else begin
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      row_ff <= row_in;
      col_ff <= col_in;
      prev_in_ff <= prev_in_in;
      center_in_ff <= center_in_in;
      center_h_ff <= center_h_in;
      ok_ff <= ok_in;
   end
endmodule

// ===== rtl/grid_peak_counter.sv =====
// grid peak counter top level: sequencer, config registers, response register
// load writes the height in the write state; a cell's peak test uses the single memory read port
// update: 10 peak tests plus a write; no new item is taken until its result is registered
// recount: one peak test per grid cell; a new item is taken while a result waits
// reset: synchronous; clears control, then sweeps all MAX_ROWS*MAX_COLS height map
// entries to zero with no item accepted (config writes still taken)
module grid_peak_counter #(
   parameter int MAX_ROWS = gpc_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = gpc_pkg::MAX_COLS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [gpc_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [gpc_pkg::ROW_W-1:0]         req_row,
   input  logic [gpc_pkg::COL_W-1:0]         req_col,
   input  logic [gpc_pkg::HEIGHT_W-1:0]      req_height,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gpc_pkg::COUNT_W-1:0]       rsp_peak_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gpc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import gpc_pkg::*;
   `include "grid_peak_counter_assert.svh"

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   typedef enum logic [6:0] {
      S_CLEAR   = 7'b0000001,
      S_IDLE    = 7'b0000010,
      S_RECOUNT = 7'b0000100,
      S_SUB     = 7'b0001000,
      S_WRITE   = 7'b0010000,
      S_ADD     = 7'b0100000,
      S_RESP    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [ROWS_CFG_W-1:0] rows_ff;
   logic [COLS_CFG_W-1:0] cols_ff;
   logic [AW-1:0] clr_ff, clr_in;
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic [2:0] nb_ff, nb_in;
   logic [ROWS_CFG_W-1:0] rc_r_ff, rc_r_in;
   logic [COLS_CFG_W-1:0] rc_c_ff, rc_c_in;
   logic go_ff, go_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [GR_W-1:0] grid_rows;
   logic [GC_W-1:0] grid_cols;
   logic req_in_grid;
   logic last_cell;
   logic signed [RC_W-1:0] ctr_row;
   logic signed [CC_W-1:0] ctr_col;
   gpc_eval_req_type eval_req;
   gpc_eval_res_type eval_res;
   logic mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [HEIGHT_W-1:0] mem_wdata, mem_rdata;
   logic rsp_free;

   assign grid_rows = (32'(rows_ff) > 32'(MAX_ROWS)) ? GR_W'(MAX_ROWS) : GR_W'(rows_ff);
   assign grid_cols = (32'(cols_ff) > 32'(MAX_COLS)) ? GC_W'(MAX_COLS) : GC_W'(cols_ff);
   assign req_in_grid = gpc_in_grid(RC_W'(req_row), CC_W'(req_col), grid_rows, grid_cols);
   assign last_cell = (GR_W'(rc_r_ff) + GR_W'(1) == grid_rows)
                   && (GC_W'(rc_c_ff) + GC_W'(1) == grid_cols);

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROWS_RESET;
         cols_ff <= COLS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROWS: rows_ff <= csr_data[ROWS_CFG_W-1:0];
            CSR_COLS: cols_ff <= csr_data[COLS_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      ctr_row = RC_W'(row_ff);
      ctr_col = CC_W'(col_ff);
      if (state_ff == S_RECOUNT) begin
         ctr_row = RC_W'(rc_r_ff);
         ctr_col = CC_W'(rc_c_ff);
      end else begin
         unique case (nb_ff)
            3'd1: ctr_row = RC_W'(row_ff) - RC_W'(1);
            3'd2: ctr_row = RC_W'(row_ff) + RC_W'(1);
            3'd3: ctr_col = CC_W'(col_ff) - CC_W'(1);
            3'd4: ctr_col = CC_W'(col_ff) + CC_W'(1);
            default: ;
         endcase
      end
   end

   assign eval_req.start = go_ff;
   assign eval_req.row = ctr_row;
   assign eval_req.col = ctr_col;

   gpc_peak_eval #(
      .MAX_COLS(MAX_COLS),
      .AW(AW)
   ) u_eval (
      .clock(clock),
      .reset(reset),
      .req(eval_req),
      .grid_rows(grid_rows),
      .grid_cols(grid_cols),
      .rd_data(mem_rdata),
      .rd_en(mem_re),
      .rd_addr(mem_raddr),
      .res(eval_res)
   );

   assign mem_we = (state_ff == S_CLEAR) || (state_ff == S_WRITE);
   assign mem_waddr = (state_ff == S_CLEAR) ? clr_ff
                    : AW'(32'(row_ff) * 32'(MAX_COLS) + 32'(col_ff));
   assign mem_wdata = (state_ff == S_CLEAR) ? '0 : height_ff;

   gpc_height_mem #(
      .DEPTH(DEPTH),
      .AW(AW),
      .DW(HEIGHT_W)
   ) u_mem (
      .clock(clock),
      .we(mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .re(mem_re),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      op_in = op_ff;
      row_in = row_ff;
      col_in = col_ff;
      height_in = height_ff;
      total_in = total_ff;
      nb_in = nb_ff;
      rc_r_in = rc_r_ff;
      rc_c_in = rc_c_ff;
      go_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_opcode;
               row_in = req_row;
               col_in = req_col;
               height_in = req_height;
               nb_in = 3'd0;
               unique case (req_opcode)
                  OP_LOAD: state_in = req_in_grid ? S_WRITE : S_IDLE;
                  OP_RECOUNT: begin
                     total_in = '0;
                     rc_r_in = '0;
                     rc_c_in = '0;
                     if (grid_rows == '0 || grid_cols == '0) begin
                        state_in = S_RESP;
                     end else begin
                        state_in = S_RECOUNT;
                        go_in = 1'b1;
                     end
                  end
                  OP_UPDATE: begin
                     if (req_in_grid) begin
                        state_in = S_SUB;
                        go_in = 1'b1;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_RECOUNT: begin
            if (eval_res.done) begin
               total_in = total_ff + COUNT_W'(eval_res.peak);
               if (last_cell) begin
                  state_in = S_RESP;
               end else begin
                  go_in = 1'b1;
                  if (GC_W'(rc_c_ff) + GC_W'(1) == grid_cols) begin
                     rc_c_in = '0;
                     rc_r_in = rc_r_ff + ROWS_CFG_W'(1);
                  end else begin
                     rc_c_in = rc_c_ff + COLS_CFG_W'(1);
                  end
               end
            end
         end
         S_SUB: begin
            if (eval_res.done) begin
               total_in = total_ff - COUNT_W'(eval_res.peak);
               if (nb_ff == 3'd4) begin
                  state_in = S_WRITE;
               end else begin
                  nb_in = nb_ff + 3'd1;
                  go_in = 1'b1;
               end
            end
         end
         S_WRITE: begin
            if (op_ff == OP_UPDATE) begin
               state_in = S_ADD;
               nb_in = 3'd0;
               go_in = 1'b1;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ADD: begin
            if (eval_res.done) begin
               total_in = total_ff + COUNT_W'(eval_res.peak);
               if (nb_ff == 3'd4) begin
                  state_in = S_RESP;
               end else begin
                  nb_in = nb_ff + 3'd1;
                  go_in = 1'b1;
               end
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = total_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         total_ff <= '0;
         go_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         total_ff <= total_in;
         go_ff <= go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
      row_ff <= row_in;
      col_ff <= col_in;
      height_ff <= height_in;
      nb_ff <= nb_in;
      rc_r_ff <= rc_r_in;
      rc_c_ff <= rc_c_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_peak_count = rsp_count_ff;

   `GPC_ASSERT_SAME(a_port_conflict, clock, reset, mem_we, !mem_re)
   `GPC_ASSERT_SAME(a_done_in_eval, clock, reset, eval_res.done,
      (state_ff == S_RECOUNT) || (state_ff == S_SUB) || (state_ff == S_ADD))
   `GPC_ASSERT_NEXT(a_rsp_loaded, clock, reset, (state_ff == S_RESP) && rsp_free,
      rsp_valid_ff && (rsp_count_ff == $past(total_ff)))
endmodule

// ===== tb/tb_grid_peak_counter.sv =====
// testbench for grid_peak_counter: random and directed load, recount and update traffic
// checked against a scoreboard class that predicts every peak count
// depends on gpc_pkg and rtl/grid_peak_counter.sv
`timescale 1ns / 1ps

class peak_scoreboard;
   bit [30:0] heights [16384];
   bit [14:0] total;
   bit [4:0]  rows_cfg;
   bit [10:0] cols_cfg;
   bit [14:0] expected_counts [$];
   int        errors;
   int        results_seen;

   function new();
      foreach (heights[i]) heights[i] = '0;
      total = '0;
      rows_cfg = gpc_pkg::ROWS_RESET;
      cols_cfg = gpc_pkg::COLS_RESET;
      errors = 0;
      results_seen = 0;
   endfunction

   function int grid_rows();
      return (rows_cfg > 16) ? 16 : int'(rows_cfg);
   endfunction

   function int grid_cols();
      return (cols_cfg > 1024) ? 1024 : int'(cols_cfg);
   endfunction

   function bit on_grid(int r, int c);
      return r >= 0 && c >= 0 && r < grid_rows() && c < grid_cols();
   endfunction

   function bit [30:0] level(int r, int c);
      if (!on_grid(r, c)) return '0;
      return heights[r * 1024 + c];
   endfunction

   function int is_peak(int r, int c);
      bit [30:0] h;
      if (!on_grid(r, c)) return 0;
      h = level(r, c);
      if (level(r - 1, c) > h || level(r + 1, c) > h ||
          level(r, c - 1) > h || level(r, c + 1) > h) return 0;
      return 1;
   endfunction

   function int peaks_around(int r, int c);
      return is_peak(r, c) + is_peak(r - 1, c) + is_peak(r + 1, c)
           + is_peak(r, c - 1) + is_peak(r, c + 1);
   endfunction

   function void apply_op(bit [1:0] op, bit [3:0] row, bit [9:0] col, bit [30:0] h);
      int r;
      int c;
      r = int'(row);
      c = int'(col);
      case (op)
         gpc_pkg::OP_LOAD: begin
            if (on_grid(r, c)) heights[r * 1024 + c] = h;
         end
         gpc_pkg::OP_RECOUNT: begin
            total = '0;
            for (int i = 0; i < grid_rows(); i++)
               for (int j = 0; j < grid_cols(); j++)
                  total = 15'(int'(total) + is_peak(i, j));
            expected_counts.push_back(total);
         end
         gpc_pkg::OP_UPDATE: begin
            if (on_grid(r, c)) begin
               total = 15'(int'(total) - peaks_around(r, c));
               heights[r * 1024 + c] = h;
               total = 15'(int'(total) + peaks_around(r, c));
            end
            expected_counts.push_back(total);
         end
         default: ;
      endcase
   endfunction

   function void match_count(bit [14:0] got);
      bit [14:0] want;
      results_seen++;
      if (expected_counts.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual %0d", $time, got);
         errors++;
         return;
      end
      want = expected_counts.pop_front();
      if (got !== want) begin
         $display("%0t: peak_count mismatch, expected %0d, actual %0d", $time, want, got);
         errors++;
      end
   endfunction
endclass

module tb_grid_peak_counter;
   import gpc_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 4000000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [OPCODE_W-1:0]   req_opcode = '0;
   logic [ROW_W-1:0]      req_row = '0;
   logic [COL_W-1:0]      req_col = '0;
   logic [HEIGHT_W-1:0]   req_height = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [COUNT_W-1:0]    rsp_peak_count;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   peak_scoreboard sb = new();
   bit  quiet = 1'b0;
   bit  hold_request = 1'b0;
   int  cycles = 0;
   int  items_sent = 0;
   int  recounts_sent = 0;

   grid_peak_counter uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_row(req_row), .req_col(req_col), .req_height(req_height),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_peak_count(rsp_peak_count),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL grid_peak_counter");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.match_count(rsp_peak_count);
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready = 1'b0;
            repeat (600) @(negedge clock);
         end else if (quiet || $urandom_range(0, 3) != 0) begin
            rsp_ready = 1'b1;
            n = quiet ? 1 : int'($urandom_range(1, 30));
            repeat (n) @(negedge clock);
         end else begin
            rsp_ready = 1'b0;
            n = int'($urandom_range(1, 17));
            repeat (n) @(negedge clock);
         end
      end
   end

   task automatic send(bit [1:0] op, bit [3:0] row, bit [9:0] col, bit [30:0] h);
      int n;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         n = int'($urandom_range(1, 17));
         repeat (n) @(negedge clock);
      end
      req_valid = 1'b1;
      req_opcode = op;
      req_row = row;
      req_col = col;
      req_height = h;
      do @(posedge clock); while (!req_ready);
      sb.apply_op(op, row, col, h);
      items_sent++;
      if (op == OP_RECOUNT) recounts_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (sb.expected_counts.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_reg(bit [0:0] idx, bit [10:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_ROWS) sb.rows_cfg = value[4:0];
      else sb.cols_cfg = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_grid(bit [10:0] rows, bit [10:0] cols);
      drain();
      write_reg(CSR_ROWS, rows);
      write_reg(CSR_COLS, cols);
   endtask

   function automatic bit [30:0] pick_height();
      case ($urandom_range(0, 9))
         0: return 31'h7fffffff;
         1, 2: return 31'($urandom());
         default: return 31'($urandom_range(0, 3));
      endcase
   endfunction

   task automatic random_items(int count, bit allow_recount);
      bit [1:0] op;
      bit [3:0] row;
      bit [9:0] col;
      int       sel;
      for (int k = 0; k < count; k++) begin
         sel = int'($urandom_range(0, 99));
         if (sel < 40) op = OP_LOAD;
         else if (sel < 90) op = OP_UPDATE;
         else if (sel < 97 && allow_recount) op = OP_RECOUNT;
         else if (sel < 97) op = OP_UPDATE;
         else op = OP_UNUSED;
         if (sb.grid_rows() > 0 && sb.grid_cols() > 0 && $urandom_range(0, 9) != 0) begin
            row = 4'($urandom_range(0, sb.grid_rows() - 1));
            col = 10'($urandom_range(0, sb.grid_cols() - 1));
         end else begin
            row = 4'($urandom());
            col = 10'($urandom());
         end
         send(op, row, col, pick_height());
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: corners, maximum heights, ties, unused opcode, full-size recount
      send(OP_UPDATE, 4'd0, 10'd0, 31'h7fffffff);
      send(OP_LOAD, 4'd15, 10'd1023, 31'h7fffffff);
      send(OP_UPDATE, 4'd15, 10'd1022, 31'h7ffffffe);
      send(OP_UPDATE, 4'd0, 10'd1, 31'h7fffffff);
      send(OP_LOAD, 4'd7, 10'd512, 31'd5);
      send(OP_UPDATE, 4'd7, 10'd513, 31'd5);
      send(OP_UPDATE, 4'd7, 10'd512, 31'd0);
      send(OP_UNUSED, 4'd3, 10'd3, 31'd9);
      send(OP_RECOUNT, 4'd0, 10'd0, 31'd0);
      send(OP_UPDATE, 4'd15, 10'd0, 31'h2aaaaaaa);
      send(OP_UPDATE, 4'd8, 10'd341, 31'h55555555);

      // grid shapes: empty, single cell, above storage, out-of-grid traffic
      set_grid(11'd0, 11'd5);
      send(OP_UPDATE, 4'd0, 10'd0, 31'd3);
      send(OP_LOAD, 4'd0, 10'd0, 31'd3);
      send(OP_RECOUNT, 4'd0, 10'd0, 31'd0);
      set_grid(11'd3, 11'd0);
      send(OP_RECOUNT, 4'd0, 10'd0, 31'd0);
      set_grid(11'd1, 11'd1);
      send(OP_UPDATE, 4'd0, 10'd0, 31'd1);
      send(OP_UPDATE, 4'd0, 10'd1, 31'd7);
      send(OP_RECOUNT, 4'd0, 10'd0, 31'd0);
      set_grid(11'd31, 11'd2047);
      send(OP_RECOUNT, 4'd0, 10'd0, 31'd0);
      send(OP_UPDATE, 4'd15, 10'd1023, 31'd0);

      set_grid(11'd2, 11'd3);
      send(OP_RECOUNT, 4'd0, 10'd0, 31'd0);
      random_items(100, 1'b1);

      // block fills up while the receiver holds off
      hold_request = 1'b1;
      random_items(30, 1'b1);
      drain();

      set_grid(11'd4, 11'd8);
      send(OP_RECOUNT, 4'd0, 10'd0, 31'd0);
      random_items(120, 1'b1);
      set_grid(11'd16, 11'd1);
      send(OP_RECOUNT, 4'd0, 10'd0, 31'd0);
      random_items(100, 1'b1);
      set_grid(11'd1, 11'd1024);
      send(OP_RECOUNT, 4'd0, 10'd0, 31'd0);
      random_items(100, 1'b0);
      set_grid(11'd16, 11'd1024);
      random_items(100, 1'b0);
      for (int p = 0; p < 4; p++) begin
         set_grid(11'($urandom_range(1, 5)), 11'($urandom_range(1, 12)));
         send(OP_RECOUNT, 4'd0, 10'd0, 31'd0);
         random_items(80, 1'b1);
      end
      set_grid(11'd3, 11'd6);
      send(OP_RECOUNT, 4'd0, 10'd0, 31'd0);
      quiet = 1'b1;
      random_items(100, 1'b1);
      drain();

      $display("sent %0d items (%0d recounts), checked %0d results",
               items_sent, recounts_sent, sb.results_seen);
      $display("grid shapes covered empty, single cell, oversize and assorted small grids");
      if (sb.errors == 0 && sb.expected_counts.size() == 0) begin
         $display("PASS grid_peak_counter");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.errors, sb.expected_counts.size());
         $display("FAIL grid_peak_counter");
      end
      $finish;
   end
endmodule
